// File: design/blu_pkg.sv
// ----------------------------------------------------------------------------
// blu_pkg
// Shared types and constants of the bilinear image upscaler.
// ----------------------------------------------------------------------------
package blu_pkg;

   localparam int IN_DIM_BITS  = 10;
   localparam int OUT_DIM_BITS = 13;
   localparam int CSR_DATA_BITS = 13;
   localparam int COORD_BITS   = 12;
   localparam int PIXEL_BITS   = 8;
   localparam int PIXEL_MAX    = 255;

   typedef enum logic [1:0] {
      CSR_IN_WIDTH   = 2'd0,
      CSR_IN_HEIGHT  = 2'd1,
      CSR_OUT_WIDTH  = 2'd2,
      CSR_OUT_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic {
      ACT_WRITE   = 1'b0,
      ACT_COMPUTE = 1'b1
   } action_type;

   // What travels alongside an item through the pipeline.
   typedef struct packed {
      logic                  valid;
      action_type            action;
      logic [COORD_BITS-1:0] col;
      logic [COORD_BITS-1:0] row;
      logic [PIXEL_BITS-1:0] pixel;
   } side_type;

endpackage

// File: design/bilinear_image_upscaler.sv
// Pipeline: one divider stage per quotient bit.
// Throughput: one item per cycle unless the output stalls; the two source stores
// each serve two reads and one write per cycle, so reads and writes never contend.
// Reset: configuration registers return to 512 and the pipeline empties; the
// source stores are not cleared and hold undefined data until written.
// ----------------------------------------------------------------------------
// bilinear_image_upscaler
// Stores a source image in two row-parity stores and produces bilinearly
// interpolated output pixels, one compute item per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module bilinear_image_upscaler #(
   parameter int MAX_IN_WIDTH  = 512,
   parameter int MAX_IN_HEIGHT = 512,
   parameter int MAX_OUT_DIM   = 4096,
   parameter int FRAC_BITS     = 7
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_action,
   input  logic [blu_pkg::COORD_BITS-1:0]  req_col,
   input  logic [blu_pkg::COORD_BITS-1:0]  req_row,
   input  logic [blu_pkg::PIXEL_BITS-1:0]  req_pixel_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [blu_pkg::PIXEL_BITS-1:0]  rsp_out_pixel,
   input  logic                            csr_write_enable,
   input  logic [1:0]                      csr_index,
   input  logic [blu_pkg::CSR_DATA_BITS-1:0] csr_write_data
);
   import blu_pkg::*;

   localparam int MAX_IN  = (MAX_IN_WIDTH > MAX_IN_HEIGHT) ? MAX_IN_WIDTH : MAX_IN_HEIGHT;
   localparam int DIM_W   = $clog2(MAX_IN + 1);
   localparam int OD_W    = $clog2(MAX_OUT_DIM + 1);
   localparam int P_W     = COORD_BITS + 1 + DIM_W;
   localparam int NUM_W   = P_W + FRAC_BITS;
   localparam int DEN_W   = OD_W + 1;
   localparam int XW      = $clog2(MAX_IN_WIDTH);
   localparam int YW      = $clog2(MAX_IN_HEIGHT);
   localparam int ROWS_HALF = (MAX_IN_HEIGHT + 1) / 2;
   localparam int DEPTH   = ROWS_HALF * MAX_IN_WIDTH;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int WW_W    = 2 * FRAC_BITS + 2;
   localparam int PR_W    = PIXEL_BITS + WW_W;
   localparam int SUM_W   = PR_W + 2;
   localparam logic [FRAC_BITS:0] WEIGHT_ONE = (FRAC_BITS + 1)'(1 << FRAC_BITS);

   function automatic logic [ADDR_W-1:0] store_addr(input int y, input int x);
      store_addr = ADDR_W'((y >> 1) * MAX_IN_WIDTH + x);
   endfunction

   // Configuration registers and saturated sizes.
   logic [IN_DIM_BITS-1:0]  in_width_ff, in_height_ff;
   logic [OUT_DIM_BITS-1:0] out_width_ff, out_height_ff;
   logic [DIM_W-1:0] iw, ih;
   logic [OD_W-1:0]  ow, oh;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff   <= IN_DIM_BITS'(512);
         in_height_ff  <= IN_DIM_BITS'(512);
         out_width_ff  <= OUT_DIM_BITS'(512);
         out_height_ff <= OUT_DIM_BITS'(512);
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_IN_WIDTH:   in_width_ff   <= csr_write_data[IN_DIM_BITS-1:0];
            CSR_IN_HEIGHT:  in_height_ff  <= csr_write_data[IN_DIM_BITS-1:0];
            CSR_OUT_WIDTH:  out_width_ff  <= csr_write_data[OUT_DIM_BITS-1:0];
            CSR_OUT_HEIGHT: out_height_ff <= csr_write_data[OUT_DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (in_width_ff == '0) iw = DIM_W'(1);
      else if (32'(in_width_ff) > MAX_IN_WIDTH) iw = DIM_W'(MAX_IN_WIDTH);
      else iw = DIM_W'(in_width_ff);
      if (in_height_ff == '0) ih = DIM_W'(1);
      else if (32'(in_height_ff) > MAX_IN_HEIGHT) ih = DIM_W'(MAX_IN_HEIGHT);
      else ih = DIM_W'(in_height_ff);
      if (out_width_ff == '0) ow = OD_W'(1);
      else if (32'(out_width_ff) > MAX_OUT_DIM) ow = OD_W'(MAX_OUT_DIM);
      else ow = OD_W'(out_width_ff);
      if (out_height_ff == '0) oh = OD_W'(1);
      else if (32'(out_height_ff) > MAX_OUT_DIM) oh = OD_W'(MAX_OUT_DIM);
      else oh = OD_W'(out_height_ff);
   end

   // Pipeline advance: only a waiting result with a result behind it stalls.
   logic     adv;
   side_type s0_ff, s1_ff, s2_ff, s3_ff, s4_ff, s5_ff;
   logic     out_valid_ff;
   logic [PIXEL_BITS-1:0] out_pixel_ff;

   assign adv = rsp_ready || !out_valid_ff ||
                !(s5_ff.valid && s5_ff.action == ACT_COMPUTE);
   assign req_ready = adv;

   // Stage 0: input register.
   side_type s0_in;
   always_comb begin
      s0_in.valid  = req_valid;
      s0_in.action = action_type'(req_action);
      s0_in.col    = req_col;
      s0_in.row    = req_row;
      s0_in.pixel  = req_pixel_value;
   end

   // Stage 1: product (2*o+1)*in.
   logic [P_W-1:0] px_ff, py_ff, px_in, py_in;
   assign px_in = P_W'({s0_ff.col, 1'b1}) * P_W'(iw);
   assign py_in = P_W'({s0_ff.row, 1'b1}) * P_W'(ih);

   // Stage 2: numerator with the fraction bits appended.
   logic [NUM_W-1:0] nx_ff, ny_ff, nx_in, ny_in;
   always_comb begin
      // A position left of the first pixel center gives index 0 and weight 0.
      if (px_ff < P_W'(ow)) nx_in = '0;
      else nx_in = {P_W'(px_ff - P_W'(ow)), FRAC_BITS'(0)};
      if (py_ff < P_W'(oh)) ny_in = '0;
      else ny_in = {P_W'(py_ff - P_W'(oh)), FRAC_BITS'(0)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff <= '0;
         s1_ff <= '0;
         s2_ff <= '0;
      end else if (adv) begin
         s0_ff <= s0_in;
         s1_ff <= s0_ff;
         s2_ff <= s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= px_in;
         py_ff <= py_in;
         nx_ff <= nx_in;
         ny_ff <= ny_in;
      end
   end

   // Divider stages, with the item's side data alongside.
   logic [NUM_W-1:0] qx, qy;

   blu_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_x (
      .clock   (clock),
      .enable  (adv),
      .num_in  (nx_ff),
      .den_in  ({ow, 1'b0}),
      .quo_out (qx)
   );

   blu_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_y (
      .clock   (clock),
      .enable  (adv),
      .num_in  (ny_ff),
      .den_in  ({oh, 1'b0}),
      .quo_out (qy)
   );

   side_type side_ff [1:NUM_W];
   for (genvar k = 1; k <= NUM_W; k++) begin : g_side
      side_type side_prev;
      if (k == 1) begin : g_first
         assign side_prev = s2_ff;
      end else begin : g_next
         assign side_prev = side_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (reset) side_ff[k] <= '0;
         else if (adv) side_ff[k] <= side_prev;
      end
   end

   // Stage 3: clamp indices, pick neighbors, split weights.
   logic [XW-1:0] x_ff, x1_ff, x_in, x1_in;
   logic [YW-1:0] y_ff, y1_ff, y_in, y1_in;
   logic [FRAC_BITS-1:0] dx_ff, dy_ff;
   always_comb begin
      if (qx[NUM_W-1:FRAC_BITS] >= P_W'(iw)) x_in = XW'(iw - DIM_W'(1));
      else x_in = XW'(qx[NUM_W-1:FRAC_BITS]);
      if (qy[NUM_W-1:FRAC_BITS] >= P_W'(ih)) y_in = YW'(ih - DIM_W'(1));
      else y_in = YW'(qy[NUM_W-1:FRAC_BITS]);
      // The last column and row replicate at the edge.
      x1_in = (DIM_W'(x_in) < iw - DIM_W'(1)) ? x_in + XW'(1) : x_in;
      y1_in = (DIM_W'(y_in) < ih - DIM_W'(1)) ? y_in + YW'(1) : y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) s3_ff <= '0;
      else if (adv) s3_ff <= side_ff[NUM_W];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff  <= x_in;
         x1_ff <= x1_in;
         y_ff  <= y_in;
         y1_ff <= y1_in;
         dx_ff <= qx[FRAC_BITS-1:0];
         dy_ff <= qy[FRAC_BITS-1:0];
      end
   end

   // Stage 4: store access. Even rows live in one store, odd rows in the other,
   // so two distinct rows of a neighborhood always come from different stores.
   logic [PIXEL_BITS-1:0] mem_even [DEPTH];
   logic [PIXEL_BITS-1:0] mem_odd  [DEPTH];
   logic [PIXEL_BITS-1:0] rd_e0_ff, rd_e1_ff, rd_o0_ff, rd_o1_ff;
   logic [YW-1:0]   y_even, y_odd;
   logic [ADDR_W-1:0] ra_e0, ra_e1, ra_o0, ra_o1, wa;
   logic            wr_en, y_par_ff, y1_par_ff;
   logic [FRAC_BITS:0] ax, ay, bx, by;
   logic [WW_W-1:0] w00_ff, w01_ff, w10_ff, w11_ff;

   always_comb begin
      y_even = y_ff[0] ? y1_ff : y_ff;
      y_odd  = y_ff[0] ? y_ff : y1_ff;
      ra_e0  = store_addr(int'(y_even), int'(x_ff));
      ra_e1  = store_addr(int'(y_even), int'(x1_ff));
      ra_o0  = store_addr(int'(y_odd), int'(x_ff));
      ra_o1  = store_addr(int'(y_odd), int'(x1_ff));
      wa     = store_addr(int'(s3_ff.row), int'(s3_ff.col));
      wr_en  = adv && s3_ff.valid && s3_ff.action == ACT_WRITE &&
               int'(s3_ff.col) < MAX_IN_WIDTH && int'(s3_ff.row) < MAX_IN_HEIGHT;
      bx     = {1'b0, dx_ff};
      by     = {1'b0, dy_ff};
      ax     = WEIGHT_ONE - bx;
      ay     = WEIGHT_ONE - by;
   end

   always_ff @(posedge clock) begin
      if (wr_en && !s3_ff.row[0]) mem_even[wa] <= s3_ff.pixel;
      if (wr_en && s3_ff.row[0])  mem_odd[wa]  <= s3_ff.pixel;
      if (adv) begin
         rd_e0_ff <= mem_even[ra_e0];
         rd_e1_ff <= mem_even[ra_e1];
         rd_o0_ff <= mem_odd[ra_o0];
         rd_o1_ff <= mem_odd[ra_o1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         y_par_ff  <= y_ff[0];
         y1_par_ff <= y1_ff[0];
         w00_ff    <= WW_W'(ax) * WW_W'(ay);
         w01_ff    <= WW_W'(bx) * WW_W'(ay);
         w10_ff    <= WW_W'(ax) * WW_W'(by);
         w11_ff    <= WW_W'(bx) * WW_W'(by);
      end
   end

   // Stage 5: weighted neighbors.
   logic [PIXEL_BITS-1:0] p0, p1, p2, p3;
   logic [PR_W-1:0] m0_ff, m1_ff, m2_ff, m3_ff;
   always_comb begin
      p0 = y_par_ff  ? rd_o0_ff : rd_e0_ff;
      p1 = y_par_ff  ? rd_o1_ff : rd_e1_ff;
      p2 = y1_par_ff ? rd_o0_ff : rd_e0_ff;
      p3 = y1_par_ff ? rd_o1_ff : rd_e1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m0_ff <= PR_W'(p0) * PR_W'(w00_ff);
         m1_ff <= PR_W'(p1) * PR_W'(w01_ff);
         m2_ff <= PR_W'(p2) * PR_W'(w10_ff);
         m3_ff <= PR_W'(p3) * PR_W'(w11_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ff <= '0;
         s5_ff <= '0;
      end else if (adv) begin
         s4_ff <= s3_ff;
         s5_ff <= s4_ff;
      end
   end

   // Stage 6: sum, scale and clamp into the output register.
   logic [SUM_W-1:0] sum, scaled;
   logic [PIXEL_BITS-1:0] out_pixel_in;
   always_comb begin
      sum    = SUM_W'(m0_ff) + SUM_W'(m1_ff) + SUM_W'(m2_ff) + SUM_W'(m3_ff);
      scaled = sum >> (2 * FRAC_BITS);
      if (scaled > SUM_W'(PIXEL_MAX)) out_pixel_in = PIXEL_BITS'(PIXEL_MAX);
      else out_pixel_in = PIXEL_BITS'(scaled);
   end

   // A waiting result stays until taken, even while write items move past it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv && s5_ff.valid && s5_ff.action == ACT_COMPUTE) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s5_ff.valid && s5_ff.action == ACT_COMPUTE) out_pixel_ff <= out_pixel_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_pixel = out_pixel_ff;

   // Clamped neighbors stay inside the source image and are adjacent.
   a_neighbors: assert property (@(posedge clock) disable iff (reset)
      (s3_ff.valid && s3_ff.action == ACT_COMPUTE) |->
         (DIM_W'(x_ff) < iw && DIM_W'(x1_ff) < iw && DIM_W'(y1_ff) < ih &&
          (x1_ff == x_ff || x1_ff == x_ff + XW'(1)) &&
          (y1_ff == y_ff || y1_ff == y_ff + YW'(1))))
      else $error("neighbor index out of range");

   // A result only appears after a compute item left the last stage.
   a_result_src: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s5_ff.valid && s5_ff.action == ACT_COMPUTE && adv))
      else $error("result without compute item");

   // The pipeline never stalls while the output can take a result.
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      (!out_valid_ff || rsp_ready) |-> req_ready)
      else $error("stall with free output");

endmodule

// File: design/blu_div.sv
// ----------------------------------------------------------------------------
// blu_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module blu_div #(
   parameter int NUM_W = 30,
   parameter int DEN_W = 14
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [NUM_W-1:0] num_in,
   input  logic [DEN_W-1:0] den_in,
   output logic [NUM_W-1:0] quo_out
);

   logic [DEN_W-1:0] a_ff [1:NUM_W];
   logic [NUM_W-1:0] q_ff [1:NUM_W];
   logic [DEN_W-1:0] d_ff [1:NUM_W];

   for (genvar k = 1; k <= NUM_W; k++) begin : g_stage
      logic [DEN_W-1:0] a_prev;
      logic [NUM_W-1:0] q_prev;
      logic [DEN_W-1:0] d_prev;
      logic [DEN_W:0]   a_shift;
      logic [DEN_W-1:0] a_in;
      logic [NUM_W-1:0] q_in;

      if (k == 1) begin : g_first
         assign a_prev = '0;
         assign q_prev = num_in;
         assign d_prev = den_in;
      end else begin : g_next
         assign a_prev = a_ff[k-1];
         assign q_prev = q_ff[k-1];
         assign d_prev = d_ff[k-1];
      end

      always_comb begin
         a_shift = {a_prev, q_prev[NUM_W-1]};
         q_in    = {q_prev[NUM_W-2:0], 1'b0};
         if (a_shift >= {1'b0, d_prev}) begin
            a_shift = a_shift - {1'b0, d_prev};
            q_in[0] = 1'b1;
         end
         a_in = a_shift[DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            a_ff[k] <= a_in;
            q_ff[k] <= q_in;
            d_ff[k] <= d_prev;
         end
      end
   end

   assign quo_out = q_ff[NUM_W];

endmodule
